// ----- rtl/bbps_pkg.sv -----
// Shared types, codes and timing constants of the buzzer beep pattern sequencer.
package bbps_pkg;

  // Command carried in the slave-side tuser.
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_SELECT  = 2'd1,
    CMD_ONESHOT = 2'd2
  } command_t;

  // Beep pattern codes.
  typedef enum logic [3:0] {
    PAT_OFF       = 4'd0,
    PAT_BOOT_PASS = 4'd1,
    PAT_BOOT_FAIL = 4'd2,
    PAT_START     = 4'd3,
    PAT_END       = 4'd4,
    PAT_FAULT     = 4'd5,
    PAT_GFCI      = 4'd6,
    PAT_BUTTON    = 4'd7,
    PAT_ONESHOT   = 4'd8
  } pattern_t;

  // Payload widths.
  localparam int unsigned SEL_W    = 4;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned OSLEN_W  = 9;
  localparam int unsigned S_DATA_W = 56;
  localparam int unsigned M_DATA_W = 8;

  // One-shot length cap in ms.
  localparam logic [OSLEN_W-1:0] ONESHOT_CAP = 9'd500;

  // Finite pattern timing in ms.
  localparam logic [TIME_W-1:0] BOOT_PASS_ON  = 32'd100;
  localparam logic [TIME_W-1:0] BOOT_PASS_END = 32'd200;
  localparam logic [TIME_W-1:0] START_ON      = 32'd200;
  localparam logic [TIME_W-1:0] START_END     = 32'd300;
  localparam logic [TIME_W-1:0] END_ON1       = 32'd100;
  localparam logic [TIME_W-1:0] END_ON2_BEGIN = 32'd200;
  localparam logic [TIME_W-1:0] END_ON2_END   = 32'd300;
  localparam logic [TIME_W-1:0] END_END       = 32'd400;
  localparam logic [TIME_W-1:0] BUTTON_ON     = 32'd30;
  localparam logic [TIME_W-1:0] BUTTON_END    = 32'd50;
  localparam logic [TIME_W-1:0] GFCI_SOLID    = 32'd5000;

  // Boot fail cycle, reduced modulo 2048 (the cycle position stays below 2000).
  localparam int unsigned CYC_W = 11;
  localparam logic [CYC_W-1:0] FAIL_PERIOD = 11'd2000;
  localparam logic [CYC_W-1:0] FAIL_A_END  = 11'd100;
  localparam logic [CYC_W-1:0] FAIL_B_BEG  = 11'd200;
  localparam logic [CYC_W-1:0] FAIL_B_END  = 11'd300;
  localparam logic [CYC_W-1:0] FAIL_C_BEG  = 11'd400;
  localparam logic [CYC_W-1:0] FAIL_C_END  = 11'd500;

  // Seconds count: dt / 1000 = ((dt >> 3) * RECIP_MUL) >> RECIP_SHIFT, exact for 32-bit dt.
  localparam int unsigned PRE_SHIFT   = 3;
  localparam int unsigned RECIP_W     = 30;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 30'd549755814;
  localparam int unsigned RECIP_SHIFT = 36;
  localparam int unsigned PROD_W      = TIME_W - PRE_SHIFT + RECIP_W;
  localparam int unsigned SEC_W       = CYC_W + 1;

  // State stage to reciprocal stage.
  typedef struct packed {
    pattern_t            pattern;
    logic                on_simple;
    logic                solid;
    logic [TIME_W-1:0]   dt;
  } s1_t;

  // Reciprocal stage to output stage.
  typedef struct packed {
    pattern_t            pattern;
    logic                on_simple;
    logic                solid;
    logic [CYC_W-1:0]    dt_lo;
    logic [SEC_W-1:0]    sec;
  } s2_t;

endpackage

// ----- rtl/buzzer_beep_pattern_sequencer.sv -----
// Buzzer beep pattern sequencer: top level joining the state, seconds and output stages.
// A tick's result reaches the master side through the input, stage, seconds and output registers.
// Throughput: one command per cycle, save under back-pressure; state updates per command.
// Select and one-shot commands are consumed without a result.
// Reset (rst, synchronous) turns the pattern off, clears the stamp and empties every stage.
module buzzer_beep_pattern_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bbps_pkg::S_DATA_W-1:0]  s_tdata,  // pattern_sel, oneshot_len_ms, now_ms, zeros
  input  logic [1:0]                     s_tuser,  // command
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bbps_pkg::M_DATA_W-1:0]  m_tdata   // buzzer_on, active_pattern, zeros
);

  logic           st_valid, st_ready;
  bbps_pkg::s1_t  st;
  logic           sc_valid, sc_ready;
  bbps_pkg::s2_t  sc;

  bbps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .down_ready (st_ready),
    .st_valid   (st_valid),
    .st         (st)
  );

  bbps_div u_div (
    .clk        (clk),
    .rst        (rst),
    .st_valid   (st_valid),
    .st_ready   (st_ready),
    .st         (st),
    .down_ready (sc_ready),
    .sc_valid   (sc_valid),
    .sc         (sc)
  );

  bbps_out u_out (
    .clk      (clk),
    .rst      (rst),
    .sc_valid (sc_valid),
    .sc_ready (sc_ready),
    .sc       (sc),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- rtl/bbps_ctrl.sv -----
// Input register, pattern state and elapsed-time stage of the beep sequencer.
module bbps_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bbps_pkg::S_DATA_W-1:0]   s_tdata,  // pattern_sel, oneshot_len_ms, now_ms, zeros
  input  logic [1:0]                      s_tuser,  // command
  input  logic                            down_ready,
  output logic                            st_valid,
  output bbps_pkg::s1_t                   st
);

  // Input register.
  logic                              in_valid;
  logic [1:0]                        in_cmd;
  logic [bbps_pkg::SEL_W-1:0]        in_sel;
  logic [bbps_pkg::LEN_W-1:0]        in_len;
  logic [bbps_pkg::TIME_W-1:0]       in_now;

  // Pattern state.
  bbps_pkg::pattern_t                cur_pattern, cur_pattern_next;
  logic [bbps_pkg::TIME_W-1:0]       start_time, start_time_next;
  logic                              stamped, stamped_next;
  logic [bbps_pkg::OSLEN_W-1:0]      oneshot_length, oneshot_length_next;

  logic                              stage_ready;
  logic                              take;
  logic                              tick_out;
  bbps_pkg::pattern_t                sel_pat;
  logic [bbps_pkg::OSLEN_W-1:0]      len_capped;
  logic [bbps_pkg::TIME_W-1:0]       base;
  logic [bbps_pkg::TIME_W-1:0]       dt;
  logic                              on_simple;
  bbps_pkg::s1_t                     st_next;

  assign stage_ready = !st_valid || down_ready;
  assign take        = in_valid && stage_ready;
  assign s_tready    = !in_valid || stage_ready;

  // Capture a transaction into the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_cmd <= s_tuser;
      in_sel <= s_tdata[3:0];
      in_len <= s_tdata[19:4];
      in_now <= s_tdata[51:20];
    end
  end

  // Command decode, start stamp and elapsed time.
  always_comb begin
    sel_pat = (in_sel > 4'(bbps_pkg::PAT_ONESHOT)) ? bbps_pkg::PAT_OFF
                                                   : bbps_pkg::pattern_t'(in_sel);
    len_capped = (in_len > 16'(bbps_pkg::ONESHOT_CAP)) ? bbps_pkg::ONESHOT_CAP
                                                       : in_len[8:0];
    base = stamped ? start_time : in_now;
    dt   = in_now - base;

    cur_pattern_next    = cur_pattern;
    start_time_next     = start_time;
    stamped_next        = stamped;
    oneshot_length_next = oneshot_length;
    tick_out            = 1'b0;
    on_simple           = 1'b0;

    unique case (bbps_pkg::command_t'(in_cmd))
      bbps_pkg::CMD_TICK: begin
        tick_out = 1'b1;
        if (cur_pattern != bbps_pkg::PAT_OFF) begin
          stamped_next    = 1'b1;
          start_time_next = base;
        end
        unique case (cur_pattern)
          bbps_pkg::PAT_BOOT_PASS: begin
            on_simple = dt < bbps_pkg::BOOT_PASS_ON;
            if (dt >= bbps_pkg::BOOT_PASS_END) cur_pattern_next = bbps_pkg::PAT_OFF;
          end
          bbps_pkg::PAT_START: begin
            on_simple = dt < bbps_pkg::START_ON;
            if (dt >= bbps_pkg::START_END) cur_pattern_next = bbps_pkg::PAT_OFF;
          end
          bbps_pkg::PAT_END: begin
            on_simple = (dt < bbps_pkg::END_ON1) ||
                        (dt >= bbps_pkg::END_ON2_BEGIN && dt < bbps_pkg::END_ON2_END);
            if (dt >= bbps_pkg::END_END) cur_pattern_next = bbps_pkg::PAT_OFF;
          end
          bbps_pkg::PAT_BUTTON: begin
            on_simple = dt < bbps_pkg::BUTTON_ON;
            if (dt >= bbps_pkg::BUTTON_END) cur_pattern_next = bbps_pkg::PAT_OFF;
          end
          bbps_pkg::PAT_ONESHOT: begin
            on_simple = dt < 32'(oneshot_length);
            if (!on_simple) cur_pattern_next = bbps_pkg::PAT_OFF;
          end
          default: begin
            // Off, and the repeating patterns whose level is settled further on.
            on_simple = 1'b0;
          end
        endcase
      end
      bbps_pkg::CMD_SELECT: begin
        if (sel_pat != cur_pattern) begin
          cur_pattern_next = sel_pat;
          stamped_next     = 1'b0;
        end
      end
      bbps_pkg::CMD_ONESHOT: begin
        if (in_len == '0) begin
          if (cur_pattern != bbps_pkg::PAT_OFF) begin
            cur_pattern_next = bbps_pkg::PAT_OFF;
            stamped_next     = 1'b0;
          end
        end else begin
          oneshot_length_next = len_capped;
          cur_pattern_next    = bbps_pkg::PAT_ONESHOT;
          stamped_next        = 1'b0;
        end
      end
      default: begin
        // Unused command code: no change.
        tick_out = 1'b0;
      end
    endcase

    st_next.pattern   = cur_pattern_next;
    st_next.on_simple = on_simple;
    st_next.solid     = dt < bbps_pkg::GFCI_SOLID;
    st_next.dt        = dt;
  end

  // State update as each command leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_pattern    <= bbps_pkg::PAT_OFF;
      start_time     <= '0;
      stamped        <= 1'b0;
      oneshot_length <= '0;
    end else if (take) begin
      cur_pattern    <= cur_pattern_next;
      start_time     <= start_time_next;
      stamped        <= stamped_next;
      oneshot_length <= oneshot_length_next;
    end
  end

  // Stage register; only ticks travel on.
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (stage_ready) begin
      st_valid <= take && tick_out;
    end
    if (take) begin
      st <= st_next;
    end
  end

endmodule

// ----- rtl/bbps_div.sv -----
// Whole-seconds stage: elapsed time divided by 1000 through a reciprocal multiply.
module bbps_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           st_valid,
  output logic           st_ready,
  input  bbps_pkg::s1_t  st,
  input  logic           down_ready,
  output logic           sc_valid,
  output bbps_pkg::s2_t  sc
);

  logic [bbps_pkg::PROD_W-1:0] prod;
  bbps_pkg::s2_t               sc_next;

  assign st_ready = !sc_valid || down_ready;

  // One 29 by 30 bit multiply; only the low bits of the quotient are kept.
  always_comb begin
    prod = bbps_pkg::PROD_W'(st.dt[bbps_pkg::TIME_W-1:bbps_pkg::PRE_SHIFT]) *
           bbps_pkg::PROD_W'(bbps_pkg::RECIP_MUL);
    sc_next.pattern   = st.pattern;
    sc_next.on_simple = st.on_simple;
    sc_next.solid     = st.solid;
    sc_next.dt_lo     = st.dt[bbps_pkg::CYC_W-1:0];
    sc_next.sec       = prod[bbps_pkg::RECIP_SHIFT +: bbps_pkg::SEC_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_valid <= 1'b0;
    end else if (st_ready) begin
      sc_valid <= st_valid;
    end
    if (st_ready && st_valid) begin
      sc <= sc_next;
    end
  end

endmodule

// ----- rtl/bbps_out.sv -----
// Final pin level for the repeating patterns and the master-side output register.
module bbps_out (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sc_valid,
  output logic                           sc_ready,
  input  bbps_pkg::s2_t                  sc,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bbps_pkg::M_DATA_W-1:0]  m_tdata
);

  logic [bbps_pkg::CYC_W-1:0] whole_periods;
  logic [bbps_pkg::CYC_W-1:0] cyc;
  logic                       on;

  assign sc_ready = !m_tvalid || m_tready;

  // Position in the 2 s boot fail cycle, worked out modulo 2048.
  always_comb begin
    whole_periods = bbps_pkg::CYC_W'(
        (2 * bbps_pkg::CYC_W)'(sc.sec[bbps_pkg::SEC_W-1:1]) *
        (2 * bbps_pkg::CYC_W)'(bbps_pkg::FAIL_PERIOD));
    cyc = sc.dt_lo - whole_periods;
    unique case (sc.pattern)
      bbps_pkg::PAT_BOOT_FAIL: begin
        on = (cyc < bbps_pkg::FAIL_A_END) ||
             (cyc >= bbps_pkg::FAIL_B_BEG && cyc < bbps_pkg::FAIL_B_END) ||
             (cyc >= bbps_pkg::FAIL_C_BEG && cyc < bbps_pkg::FAIL_C_END);
      end
      bbps_pkg::PAT_FAULT: on = !sc.sec[0];
      // After the solid 5 s, an odd second count is an even count past the solid part.
      bbps_pkg::PAT_GFCI:  on = sc.solid || sc.sec[0];
      default:             on = sc.on_simple;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (sc_ready) begin
      m_tvalid <= sc_valid;
    end
    if (sc_ready && sc_valid) begin
      m_tdata <= {3'b000, sc.pattern, on};
    end
  end

endmodule

// ----- rtl/bbps_checker.sv -----
// Port-level checks of the beep sequencer and their binding to the top level.
module bbps_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [bbps_pkg::M_DATA_W-1:0]  m_tdata
);

  // A stalled result keeps its valid.
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result valid dropped while stalled");

  // A stalled result keeps its data.
  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result data changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // The reported pattern is always a defined code.
  a_pattern_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[4:1] <= 4'(bbps_pkg::PAT_ONESHOT))
    else $error("active pattern out of range");

  // The buzzer never sounds once the pattern has fallen back to off.
  a_on_needs_pattern: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[4:1] != 4'(bbps_pkg::PAT_OFF))
    else $error("buzzer on with pattern off");

endmodule

bind buzzer_beep_pattern_sequencer bbps_checker u_bbps_checker (.*);

// ----- dv/tb_buzzer_beep_pattern_sequencer.sv -----
// Testbench for the buzzer beep pattern sequencer: directed table, random command runs, scoreboard.
`timescale 1ns / 100ps

module tb_buzzer_beep_pattern_sequencer;

  // Reserved command code, which the block must ignore.
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  // Pattern timing in ms, as the buzzer is specified.
  localparam logic [31:0] PASS_ON_MS   = 32'd100;
  localparam logic [31:0] PASS_END_MS  = 32'd200;
  localparam logic [31:0] FAIL_CYC_MS  = 32'd2000;
  localparam logic [31:0] START_ON_MS  = 32'd200;
  localparam logic [31:0] START_END_MS = 32'd300;
  localparam logic [31:0] END_END_MS   = 32'd400;
  localparam logic [31:0] SECOND_MS    = 32'd1000;
  localparam logic [31:0] SOLID_MS     = 32'd5000;
  localparam logic [31:0] BTN_ON_MS    = 32'd30;
  localparam logic [31:0] BTN_END_MS   = 32'd50;
  localparam logic [15:0] LEN_CAP_MS   = 16'd500;

  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 8;

  typedef struct packed {
    logic               on;
    bbps_pkg::pattern_t pat;
  } beep_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [3:0]  sel;
    logic [15:0] len;
    logic [31:0] now;
    bit          typed;
    beep_t       result;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [bbps_pkg::S_DATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = bbps_pkg::CMD_TICK;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [bbps_pkg::M_DATA_W-1:0] m_tdata;

  // Predicted block state.
  bbps_pkg::pattern_t pat_now = bbps_pkg::PAT_OFF;
  logic [31:0] stamp_ms = '0;
  logic        stamp_valid = 1'b0;
  logic [8:0]  oneshot_ms = '0;

  beep_t beep_expected_q [$];
  int errors = 0;
  int cmds_accepted = 0;
  int ticks_checked = 0;
  logic [15:0] patterns_seen = '0;
  bit calm = 1'b0;
  bit hold_request = 1'b0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  buzzer_beep_pattern_sequencer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // A pattern change clears the start stamp; codes above one-shot mean off.
  function automatic void choose_pattern(input logic [3:0] code);
    bbps_pkg::pattern_t p;
    p = (code > bbps_pkg::PAT_ONESHOT) ? bbps_pkg::PAT_OFF : bbps_pkg::pattern_t'(code);
    if (p != pat_now) begin
      pat_now = p;
      stamp_valid = 1'b0;
    end
  endfunction

  // Advances the predicted state by one command; a tick yields the pin level.
  task automatic predict_beep(input logic [1:0] cmd, input logic [3:0] sel,
                              input logic [15:0] len, input logic [31:0] now,
                              output bit has_result, output beep_t res);
    logic [31:0] dt;
    logic [31:0] cyc;
    logic        on;
    has_result = 1'b0;
    res = '{1'b0, bbps_pkg::PAT_OFF};
    case (cmd)
      bbps_pkg::CMD_TICK: begin
        on = 1'b0;
        if (pat_now != bbps_pkg::PAT_OFF) begin
          if (!stamp_valid) begin
            stamp_ms = now;
            stamp_valid = 1'b1;
          end
          dt = now - stamp_ms;
          case (pat_now)
            bbps_pkg::PAT_BOOT_PASS: begin
              on = dt < PASS_ON_MS;
              if (dt >= PASS_END_MS) pat_now = bbps_pkg::PAT_OFF;
            end
            bbps_pkg::PAT_BOOT_FAIL: begin
              cyc = dt % FAIL_CYC_MS;
              on = (cyc < 32'd100) || (cyc >= 32'd200 && cyc < 32'd300) ||
                   (cyc >= 32'd400 && cyc < 32'd500);
            end
            bbps_pkg::PAT_START: begin
              on = dt < START_ON_MS;
              if (dt >= START_END_MS) pat_now = bbps_pkg::PAT_OFF;
            end
            bbps_pkg::PAT_END: begin
              on = (dt < 32'd100) || (dt >= 32'd200 && dt < 32'd300);
              if (dt >= END_END_MS) pat_now = bbps_pkg::PAT_OFF;
            end
            bbps_pkg::PAT_FAULT: on = ((dt / SECOND_MS) & 32'd1) == 32'd0;
            bbps_pkg::PAT_GFCI: begin
              if (dt < SOLID_MS) on = 1'b1;
              else on = (((dt - SOLID_MS) / SECOND_MS) & 32'd1) == 32'd0;
            end
            bbps_pkg::PAT_BUTTON: begin
              on = dt < BTN_ON_MS;
              if (dt >= BTN_END_MS) pat_now = bbps_pkg::PAT_OFF;
            end
            bbps_pkg::PAT_ONESHOT: begin
              on = dt < {23'd0, oneshot_ms};
              if (dt >= {23'd0, oneshot_ms}) pat_now = bbps_pkg::PAT_OFF;
            end
            default: on = 1'b0;
          endcase
        end
        has_result = 1'b1;
        res = '{on, pat_now};
      end
      bbps_pkg::CMD_SELECT: choose_pattern(sel);
      bbps_pkg::CMD_ONESHOT: begin
        if (len == 16'd0) begin
          choose_pattern(bbps_pkg::PAT_OFF);
        end else begin
          oneshot_ms = (len > LEN_CAP_MS) ? LEN_CAP_MS[8:0] : len[8:0];
          pat_now = bbps_pkg::PAT_ONESHOT;
          stamp_valid = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  // Offers one command, waits for its transaction and records what it should produce.
  task automatic send_cmd(input logic [1:0] cmd, input logic [3:0] sel,
                          input logic [15:0] len, input logic [31:0] now,
                          input bit typed, input beep_t typed_res);
    bit    has_result;
    beep_t res;
    if (!calm && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {4'd0, now, len, sel};
    do @(posedge clk); while (!s_tready);
    cmds_accepted++;
    predict_beep(cmd, sel, len, now, has_result, res);
    if (has_result) beep_expected_q.push_back(typed ? typed_res : res);
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= calm || ($urandom_range(99) >= 10);
    end
  end

  // Scoreboard: each result against the oldest expectation.
  always @(posedge clk) begin : check_results
    beep_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (beep_expected_q.size() == 0) begin
        report_mismatch("result with nothing outstanding", {24'd0, m_tdata}, 32'd0);
      end else begin
        want = beep_expected_q.pop_front();
        if (m_tdata[0] !== want.on)
          report_mismatch("buzzer_on", {31'd0, m_tdata[0]}, {31'd0, want.on});
        if (m_tdata[4:1] !== want.pat)
          report_mismatch("active_pattern", {28'd0, m_tdata[4:1]}, {28'd0, want.pat});
        patterns_seen[want.pat] = 1'b1;
        ticks_checked++;
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    cmd_row_t    directed_rows [$];
    cmd_row_t    row;
    beep_t       none;
    int          n_items;
    int          run_len;
    int          pick;
    logic [31:0] clock_ms;
    logic [3:0]  seq_pat;
    logic [15:0] seq_len;
    logic [1:0]  seq_cmd;
    bit          slow_pattern;
    bit          hold_done;
    bit          drain_done;

    none = '{1'b0, bbps_pkg::PAT_OFF};
    // Extremes, reserved code, out-of-range select, zero-length one-shot,
    // reselection, restart of a running one-shot and the wrap of the clock.
    directed_rows.push_back('{bbps_pkg::CMD_TICK, 4'h0, 16'h0000, 32'h0000_0000, 1'b1, none});
    directed_rows.push_back('{bbps_pkg::CMD_TICK, 4'hF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, none});
    directed_rows.push_back('{CMD_RESERVED, 4'hF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, none});
    directed_rows.push_back('{bbps_pkg::CMD_SELECT, bbps_pkg::PAT_ONESHOT, 16'h0, 32'h0,
                              1'b0, none});
    directed_rows.push_back('{bbps_pkg::CMD_TICK, 4'h0, 16'h0, 32'd1234, 1'b1, none});
    directed_rows.push_back('{bbps_pkg::CMD_SELECT, 4'hF, 16'h0, 32'h0, 1'b0, none});
    directed_rows.push_back('{bbps_pkg::CMD_TICK, 4'h0, 16'h0, 32'd77, 1'b1, none});
    directed_rows.push_back('{bbps_pkg::CMD_SELECT, bbps_pkg::PAT_BOOT_PASS, 16'h0, 32'h0,
                              1'b0, none});
    directed_rows.push_back('{bbps_pkg::CMD_TICK, 4'h0, 16'h0, 32'd1000, 1'b0, none});
    directed_rows.push_back('{bbps_pkg::CMD_TICK, 4'h0, 16'h0, 32'd1099, 1'b0, none});
    directed_rows.push_back('{bbps_pkg::CMD_TICK, 4'h0, 16'h0, 32'd1100, 1'b0, none});
    directed_rows.push_back('{bbps_pkg::CMD_SELECT, bbps_pkg::PAT_BOOT_FAIL, 16'h0, 32'h0,
                              1'b0, none});
    directed_rows.push_back('{bbps_pkg::CMD_TICK, 4'h0, 16'h0, 32'hFFFF_FF00, 1'b0, none});
    directed_rows.push_back('{bbps_pkg::CMD_TICK, 4'h0, 16'h0, 32'h0000_0000, 1'b0, none});
    directed_rows.push_back('{bbps_pkg::CMD_SELECT, bbps_pkg::PAT_BOOT_FAIL, 16'h0, 32'h0,
                              1'b0, none});
    directed_rows.push_back('{bbps_pkg::CMD_TICK, 4'h0, 16'h0, 32'h0000_01F3, 1'b0, none});
    directed_rows.push_back('{bbps_pkg::CMD_ONESHOT, 4'h0, 16'hFFFF, 32'h0, 1'b0, none});
    directed_rows.push_back('{bbps_pkg::CMD_TICK, 4'h0, 16'h0, 32'd5000, 1'b0, none});
    directed_rows.push_back('{bbps_pkg::CMD_TICK, 4'h0, 16'h0, 32'd5499, 1'b0, none});
    directed_rows.push_back('{bbps_pkg::CMD_ONESHOT, 4'h0, 16'd7, 32'h0, 1'b0, none});
    directed_rows.push_back('{bbps_pkg::CMD_TICK, 4'h0, 16'h0, 32'd6000, 1'b0, none});
    directed_rows.push_back('{bbps_pkg::CMD_TICK, 4'h0, 16'h0, 32'd6007, 1'b0, none});
    directed_rows.push_back('{bbps_pkg::CMD_ONESHOT, 4'h0, 16'd0, 32'h0, 1'b0, none});
    directed_rows.push_back('{bbps_pkg::CMD_TICK, 4'h0, 16'h0, 32'd6100, 1'b1, none});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_cmd(row.cmd, row.sel, row.len, row.now, row.typed, row.result);
    end

    // Random runs: pick a pattern, then a stream of rising timestamps.
    n_items = 0;
    hold_done = 1'b0;
    drain_done = 1'b0;
    clock_ms = $urandom;
    while (n_items < RANDOM_ITEMS) begin
      if (n_items >= 150 && n_items < 250) calm = 1'b1;
      else calm = 1'b0;
      if (!hold_done && n_items >= 100) begin
        hold_done = 1'b1;
        hold_request = 1'b1;
      end
      if (!drain_done && n_items >= 300) begin
        drain_done = 1'b1;
        s_tvalid <= 1'b0;
        while (beep_expected_q.size() != 0) @(posedge clk);
      end

      pick = $urandom_range(99);
      if (pick < 15) begin
        // Noise: any command with any fields.
        seq_cmd = 2'($urandom_range(3));
        send_cmd(seq_cmd, 4'($urandom_range(15)), 16'($urandom_range(65535)), $urandom,
                 1'b0, none);
        if (seq_cmd != CMD_RESERVED) n_items++;
      end else begin
        // Start a pattern, by select or by one-shot command.
        if ($urandom_range(99) < 25) begin
          pick = $urandom_range(99);
          if (pick < 10) seq_len = 16'd0;
          else if (pick < 70) seq_len = 16'($urandom_range(1, 600));
          else seq_len = 16'($urandom_range(65535));
          send_cmd(bbps_pkg::CMD_ONESHOT, 4'($urandom_range(15)), seq_len, $urandom,
                   1'b0, none);
          seq_pat = bbps_pkg::PAT_ONESHOT;
        end else begin
          seq_pat = ($urandom_range(99) < 8) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(8));
          send_cmd(bbps_pkg::CMD_SELECT, seq_pat, 16'($urandom_range(65535)), $urandom,
                   1'b0, none);
        end
        n_items++;
        slow_pattern = (seq_pat == bbps_pkg::PAT_BOOT_FAIL) ||
                       (seq_pat == bbps_pkg::PAT_FAULT) ||
                       (seq_pat == bbps_pkg::PAT_GFCI);
        if ($urandom_range(99) < 10) clock_ms = 32'hFFFF_FFFF - $urandom_range(3000);
        run_len = $urandom_range(2, 12);
        repeat (run_len) begin
          if ($urandom_range(99) < 5)
            send_cmd(bbps_pkg::CMD_SELECT, seq_pat, 16'($urandom_range(65535)), $urandom,
                     1'b0, none);
          clock_ms = clock_ms + (slow_pattern ? $urandom_range(0, 1500)
                                              : $urandom_range(0, 80));
          send_cmd(bbps_pkg::CMD_TICK, 4'($urandom_range(15)), 16'($urandom_range(65535)),
                   clock_ms, 1'b0, none);
          n_items++;
        end
      end
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    // Drain and let the pipeline settle.
    while (beep_expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (beep_expected_q.size() != 0)
      report_mismatch("results still outstanding", beep_expected_q.size(), 32'd0);

    $display("Run covered %0d commands and %0d checked ticks across the pattern set.",
             cmds_accepted, ticks_checked);
    $display("Patterns seen in results (bit per code): %b", patterns_seen[8:0]);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
